// ===== design/nearest_palette_color_unit_defines.svh =====
// Assertion macros used by the checker file of the nearest palette color unit.
`ifndef NEAREST_PALETTE_COLOR_UNIT_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nearest palette color unit: check failed");

// The consequent must hold in the cycle after the antecedent.
`define NPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nearest palette color unit: check failed");

`endif

// ===== design/npc_pkg.sv =====
// Types and constants of the nearest palette color unit.
package npc_pkg;

  localparam int NUM_REGS = 7;
  localparam int COMP_W   = 8;
  localparam int ENTRY_W  = 3 * COMP_W;
  localparam int SQ_W     = 2 * COMP_W;
  localparam int DIST_W   = SQ_W + 2;
  localparam int IDX_W    = 3;

  localparam logic [ENTRY_W-1:0] RESET_PALETTE [NUM_REGS] = '{
    24'h000000, 24'hFFFFFF, 24'h00FF00, 24'h0000FF,
    24'hFF0000, 24'hFFFF00, 24'hFF8000
  };

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic              end_of_frame;
  } pixel_t;

  typedef struct packed {
    logic [IDX_W-1:0] color_index;
    logic             frame_done;
  } result_t;

endpackage

// ===== design/npc_dist_calc.sv =====
// Squared Euclidean distance between a pixel and one packed palette entry.
module npc_dist_calc (
  input  npc_pkg::pixel_t                 pixel,
  input  logic [npc_pkg::ENTRY_W-1:0]     entry,
  output logic [npc_pkg::DIST_W-1:0]      sq_dist
);

  logic [npc_pkg::COMP_W-1:0] ent_r_c;
  logic [npc_pkg::COMP_W-1:0] ent_g_c;
  logic [npc_pkg::COMP_W-1:0] ent_b_c;
  logic [npc_pkg::COMP_W-1:0] dr;
  logic [npc_pkg::COMP_W-1:0] dg;
  logic [npc_pkg::COMP_W-1:0] db;
  logic [npc_pkg::SQ_W-1:0]   sq_r;
  logic [npc_pkg::SQ_W-1:0]   sq_g;
  logic [npc_pkg::SQ_W-1:0]   sq_b;

  assign ent_r_c = entry[3*npc_pkg::COMP_W-1:2*npc_pkg::COMP_W];
  assign ent_g_c = entry[2*npc_pkg::COMP_W-1:npc_pkg::COMP_W];
  assign ent_b_c = entry[npc_pkg::COMP_W-1:0];

  assign dr = (pixel.red   > ent_r_c) ? pixel.red   - ent_r_c : ent_r_c - pixel.red;
  assign dg = (pixel.green > ent_g_c) ? pixel.green - ent_g_c : ent_g_c - pixel.green;
  assign db = (pixel.blue  > ent_b_c) ? pixel.blue  - ent_b_c : ent_b_c - pixel.blue;

  assign sq_r = npc_pkg::SQ_W'(dr) * npc_pkg::SQ_W'(dr);
  assign sq_g = npc_pkg::SQ_W'(dg) * npc_pkg::SQ_W'(dg);
  assign sq_b = npc_pkg::SQ_W'(db) * npc_pkg::SQ_W'(db);

  assign sq_dist = npc_pkg::DIST_W'(sq_r) + npc_pkg::DIST_W'(sq_g) + npc_pkg::DIST_W'(sq_b);

endmodule

// ===== design/nearest_palette_color_unit.sv =====
// A pixel accepted with start passes the input, distance and result registers before out_valid rises.
// Throughput: one pixel per clock; busy stays low, since the result side cannot stall.
// The three stages are the input register, the per-entry distance register and the
// result register that holds the winner of the lowest-index-first compare chain.
// Reset clears all stage valid bits and loads the default palette.
module nearest_palette_color_unit #(
  parameter int PALETTE_SIZE = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  npc_pkg::pixel_t               in_pixel,
  output logic                          out_valid,
  output npc_pkg::result_t              out_result,
  input  logic                          cfg_we,
  input  logic [npc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [npc_pkg::ENTRY_W-1:0]   cfg_data
);

  logic [npc_pkg::ENTRY_W-1:0] palette_r [PALETTE_SIZE];

  logic                        in_valid_r;
  npc_pkg::pixel_t             pix_r;
  logic [npc_pkg::DIST_W-1:0]  dist_c [PALETTE_SIZE];
  logic                        dist_valid_r;
  logic [npc_pkg::DIST_W-1:0]  dist_r [PALETTE_SIZE];
  logic                        eof_r;
  logic                        out_valid_r;
  npc_pkg::result_t            out_result_r;
  npc_pkg::result_t            result_nxt;

  assign busy = 1'b0;

  for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_entry
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        palette_r[i] <= npc_pkg::RESET_PALETTE[i];
      end else if (cfg_we && cfg_index == npc_pkg::IDX_W'(i)) begin
        palette_r[i] <= cfg_data;
      end
    end

    npc_dist_calc u_dist (
      .pixel   (pix_r),
      .entry   (palette_r[i]),
      .sq_dist (dist_c[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      dist_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      in_valid_r   <= start && !busy;
      dist_valid_r <= in_valid_r;
      out_valid_r  <= dist_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    pix_r        <= in_pixel;
    dist_r       <= dist_c;
    eof_r        <= pix_r.end_of_frame;
    out_result_r <= result_nxt;
  end

  always_comb begin
    logic [npc_pkg::DIST_W-1:0] best_d;
    logic [npc_pkg::IDX_W-1:0]  best_i;
    best_d = dist_r[0];
    best_i = '0;
    for (int i = 1; i < PALETTE_SIZE; i++) begin
      if (dist_r[i] < best_d) begin
        best_d = dist_r[i];
        best_i = npc_pkg::IDX_W'(i);
      end
    end
    result_nxt.color_index = best_i;
    result_nxt.frame_done  = eof_r;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

// ===== design/npc_checker.sv =====
// Port-level checker of the nearest palette color unit and its bind statement.
`include "nearest_palette_color_unit_defines.svh"

module npc_checker #(
  parameter int PALETTE_SIZE = 7
) (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input npc_pkg::pixel_t  in_pixel,
  input logic             out_valid,
  input npc_pkg::result_t out_result
);

  `NPC_ASSERT_SAME(a_never_busy, clk, rst_n, 1'b1, !busy)
  `NPC_ASSERT_NEXT(a_beat_emerges, clk, rst_n, start && !busy, ##2 out_valid)
  `NPC_ASSERT_SAME(a_no_spurious_beat, clk, rst_n, out_valid, $past(start && !busy, 3))
  `NPC_ASSERT_SAME(a_eof_follows, clk, rst_n, out_valid,
    out_result.frame_done == $past(in_pixel.end_of_frame, 3))
  `NPC_ASSERT_SAME(a_index_in_range, clk, rst_n, out_valid,
    32'(out_result.color_index) < PALETTE_SIZE)

endmodule

bind nearest_palette_color_unit npc_checker #(.PALETTE_SIZE(PALETTE_SIZE)) u_npc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_pixel   (in_pixel),
  .out_valid  (out_valid),
  .out_result (out_result)
);
